/* hw/rtl/b85_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// b85_pkg
// Shared constants, types and the alphabet lookup for the base-85 encoder.
// ----------------------------------------------------------------------------
package b85_pkg;

    localparam int GROUP_W     = 32;
    localparam int DIGIT_W     = 7;
    localparam int NUM_DIGITS  = 5;
    localparam int NSYM_W      = 3;
    localparam int STEP_W      = 3;

    localparam logic [DIGIT_W-1:0] B85_TOP   = 7'd84;

    // floor(x / 85) == (x * B85_RECIP) >> B85_SHIFT for every 32-bit x
    localparam logic [GROUP_W-1:0] B85_RECIP = 32'd3233857729;
    localparam int                 B85_SHIFT = 38;
    localparam int                 QUO_W     = 2 * GROUP_W - B85_SHIFT;

    localparam int QUEUE_DEPTH = 2;
    localparam int QUEUE_PTR_W = 1;

    localparam logic [NUM_DIGITS*8*17-1:0] ALPHABET =
        "0123456789ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz!#$%&()*+-;<=>?@^_`{|}~";

    typedef struct packed {
        logic [GROUP_W-1:0] value;
        logic [NSYM_W-1:0]  nsym;
        logic               last;
    } b85_job_t;

    typedef enum logic [1:0] {
        DU_IDLE,
        DU_CALC,
        DU_DONE
    } b85_du_state_t;

    function automatic logic [7:0] b85_symbol(input logic [DIGIT_W-1:0] digit);
        logic [DIGIT_W-1:0] pos;
        logic [7:0]         sym;
        pos = B85_TOP - digit;
        if (digit > B85_TOP)
        begin
            sym = 8'h30;
        end
        else
        begin
            sym = ALPHABET[{pos, 3'b000} +: 8];
        end
        return sym;
    endfunction

endpackage

/* hw/rtl/b85_byte_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// b85_byte_if
// Byte channel: one raw stream byte per word, with a final-byte flag.
// ----------------------------------------------------------------------------
interface b85_byte_if;

    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       stream_last;

    modport source (output valid, output data_byte, output stream_last, input ready);
    modport sink   (input valid, input data_byte, input stream_last, output ready);

endinterface

/* hw/rtl/b85_sym_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// b85_sym_if
// Symbol channel: one base-85 ASCII character per word.
// ----------------------------------------------------------------------------
interface b85_sym_if;

    logic       valid;
    logic       ready;
    logic [7:0] symbol;
    logic       run_last;
    logic       stream_end;

    modport source (output valid, output symbol, output run_last, output stream_end,
                    input ready);
    modport sink   (input valid, input symbol, input run_last, input stream_end,
                    output ready);

endinterface

/* hw/rtl/base85_stream_encoder.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// base85_stream_encoder
// Byte stream to base-85 text encoder, RFC 1924 alphabet.
// ----------------------------------------------------------------------------
//  channel   dir  word                                   handshake
//  bytes     in   data_byte[7:0], stream_last            valid / ready
//  symbols   out  symbol[7:0], run_last, stream_end      valid / ready
//
//  A byte is taken every cycle while the two-entry group queue has room.
//  Each group takes one load and five steps of the digit unit's single
//  32x32 reciprocal multiplier; symbols leave at one per cycle unless stalled.
//  The digit unit splits the next group while the last one's symbols leave.
//  rst_n clears the gathered group, the queue and all valid flags.
//  A stall on symbols backs up through the emitter, digit unit and queue.
// ----------------------------------------------------------------------------
module base85_stream_encoder
    import b85_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    b85_byte_if.sink  bytes,
    b85_sym_if.source symbols
);

    logic     q_push;
    logic     q_full;
    logic     q_valid;
    logic     q_pop;
    b85_job_t q_push_job;
    b85_job_t q_pop_job;

    b85_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .bytes    (bytes),
        .push     (q_push),
        .push_job (q_push_job),
        .full     (q_full)
    );

    b85_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (q_push),
        .push_job (q_push_job),
        .full     (q_full),
        .valid    (q_valid),
        .pop      (q_pop),
        .pop_job  (q_pop_job)
    );

    b85_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .valid    (q_valid),
        .pop      (q_pop),
        .pop_job  (q_pop_job),
        .symbols  (symbols)
    );

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        q_push |-> !q_full)
        else $error("group queue overflow");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> q_valid)
        else $error("group queue underflow");

    a_end_on_run_last: assert property (@(posedge clk) disable iff (!rst_n)
        (symbols.valid && symbols.stream_end) |-> symbols.run_last)
        else $error("stream end off a run boundary");

    a_short_job: assert property (@(posedge clk) disable iff (!rst_n)
        (q_push && !q_push_job.last) |-> (q_push_job.nsym == 3'd5))
        else $error("short group without final flag");

endmodule

/* hw/rtl/b85_front.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// b85_front
// Gathers bytes into a big-endian group and queues a job per finished group.
// ----------------------------------------------------------------------------
module b85_front
    import b85_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    b85_byte_if.sink      bytes,
    output logic          push,
    output b85_job_t      push_job,
    input  logic          full
);

    logic [23:0] group_value_reg;
    logic [23:0] group_value_next;
    logic [1:0]  byte_count_reg;
    logic [1:0]  byte_count_next;
    logic        accept;
    logic        close;

    assign bytes.ready = !full;
    assign accept      = bytes.valid && !full;
    assign close       = (byte_count_reg == 2'd3) || bytes.stream_last;
    assign push        = accept && close;

    always_comb
    begin
        push_job.last = bytes.stream_last;
        if (byte_count_reg == 2'd3)
        begin
            push_job.nsym = 3'd5;
        end
        else
        begin
            push_job.nsym = {1'b0, byte_count_reg} + 3'd2;
        end
        case (byte_count_reg)
            2'd0:    push_job.value = {bytes.data_byte, 24'h000000};
            2'd1:    push_job.value = {group_value_reg[7:0], bytes.data_byte, 16'h0000};
            2'd2:    push_job.value = {group_value_reg[15:0], bytes.data_byte, 8'h00};
            default: push_job.value = {group_value_reg, bytes.data_byte};
        endcase
    end

    always_comb
    begin
        group_value_next = group_value_reg;
        byte_count_next  = byte_count_reg;
        if (accept)
        begin
            if (close)
            begin
                group_value_next = '0;
                byte_count_next  = '0;
            end
            else
            begin
                group_value_next = {group_value_reg[15:0], bytes.data_byte};
                byte_count_next  = byte_count_reg + 2'd1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            group_value_reg <= '0;
            byte_count_reg  <= '0;
        end
        else
        begin
            group_value_reg <= group_value_next;
            byte_count_reg  <= byte_count_next;
        end
    end

endmodule

/* hw/rtl/b85_queue.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// b85_queue
// Short job queue between the byte front end and the encoding back end.
// ----------------------------------------------------------------------------
module b85_queue
    import b85_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     push,
    input  b85_job_t push_job,
    output logic     full,
    output logic     valid,
    input  logic     pop,
    output b85_job_t pop_job
);

    b85_job_t                 entry_reg [QUEUE_DEPTH];
    logic [QUEUE_PTR_W-1:0]   wr_ptr_reg;
    logic [QUEUE_PTR_W-1:0]   wr_ptr_next;
    logic [QUEUE_PTR_W-1:0]   rd_ptr_reg;
    logic [QUEUE_PTR_W-1:0]   rd_ptr_next;
    logic [QUEUE_PTR_W:0]     count_reg;
    logic [QUEUE_PTR_W:0]     count_next;

    assign full    = (count_reg == (QUEUE_PTR_W+1)'(QUEUE_DEPTH));
    assign valid   = (count_reg != '0);
    assign pop_job = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_job;
        end
    end

endmodule

/* hw/rtl/b85_back.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// b85_back
// Splits each group into base-85 digits with a shared reciprocal multiplier,
// then emits the alphabet symbols one per word through an output register.
// ----------------------------------------------------------------------------
module b85_back
    import b85_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      valid,
    output logic      pop,
    input  b85_job_t  pop_job,
    b85_sym_if.source symbols
);

    b85_du_state_t       du_state_reg;
    b85_du_state_t       du_state_next;
    logic [STEP_W-1:0]   du_step_reg;
    logic [GROUP_W-1:0]  du_val_reg;
    logic [DIGIT_W-1:0]  du_dig_reg [NUM_DIGITS];
    logic [NSYM_W-1:0]   du_nsym_reg;
    logic                du_last_reg;

    logic                em_busy_reg;
    logic [DIGIT_W-1:0]  em_dig_reg [NUM_DIGITS];
    logic [NSYM_W-1:0]   em_left_reg;
    logic                em_last_reg;

    logic                out_valid_reg;
    logic [7:0]          symbol_reg;
    logic                run_last_reg;
    logic                stream_end_reg;

    logic [2*GROUP_W-1:0] product;
    logic [QUO_W-1:0]     quotient;
    logic [DIGIT_W-1:0]   quo_low;
    logic [DIGIT_W-1:0]   quo_times_radix;
    logic [DIGIT_W-1:0]   remainder;
    logic                 out_free;
    logic                 em_adv;
    logic                 em_final;
    logic                 em_load;

    assign product         = du_val_reg * B85_RECIP;
    assign quotient        = product[2*GROUP_W-1:B85_SHIFT];
    assign quo_low         = quotient[DIGIT_W-1:0];
    assign quo_times_radix = quo_low + (quo_low << 2) + (quo_low << 4) + (quo_low << 6);
    assign remainder       = du_val_reg[DIGIT_W-1:0] - quo_times_radix;

    assign out_free = !out_valid_reg || symbols.ready;
    assign em_adv   = em_busy_reg && out_free;
    assign em_final = (em_left_reg == 3'd1);
    assign em_load  = (du_state_reg == DU_DONE) && (!em_busy_reg || (em_adv && em_final));

    assign symbols.valid      = out_valid_reg;
    assign symbols.symbol     = symbol_reg;
    assign symbols.run_last   = run_last_reg;
    assign symbols.stream_end = stream_end_reg;

    always_comb
    begin
        du_state_next = du_state_reg;
        pop           = 1'b0;
        case (du_state_reg)
            DU_IDLE:
            begin
                if (valid)
                begin
                    pop           = 1'b1;
                    du_state_next = DU_CALC;
                end
            end
            DU_CALC:
            begin
                if (du_step_reg == STEP_W'(NUM_DIGITS - 1))
                begin
                    du_state_next = DU_DONE;
                end
            end
            DU_DONE:
            begin
                if (em_load)
                begin
                    if (valid)
                    begin
                        pop           = 1'b1;
                        du_state_next = DU_CALC;
                    end
                    else
                    begin
                        du_state_next = DU_IDLE;
                    end
                end
            end
            default:
            begin
                du_state_next = DU_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            du_state_reg   <= DU_IDLE;
            du_step_reg    <= '0;
            em_busy_reg    <= 1'b0;
            em_left_reg    <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            du_state_reg <= du_state_next;
            if (pop)
            begin
                du_step_reg <= '0;
            end
            else if (du_state_reg == DU_CALC)
            begin
                du_step_reg <= du_step_reg + 1'b1;
            end
            if (em_load)
            begin
                em_busy_reg <= 1'b1;
                em_left_reg <= du_nsym_reg;
            end
            else if (em_adv)
            begin
                em_left_reg <= em_left_reg - 1'b1;
                if (em_final)
                begin
                    em_busy_reg <= 1'b0;
                end
            end
            if (em_adv)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (symbols.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            du_val_reg  <= pop_job.value;
            du_nsym_reg <= pop_job.nsym;
            du_last_reg <= pop_job.last;
        end
        else if (du_state_reg == DU_CALC)
        begin
            du_val_reg    <= {{(GROUP_W-QUO_W){1'b0}}, quotient};
            du_dig_reg[0] <= remainder;
            for (int i = 1; i < NUM_DIGITS; i++)
            begin
                du_dig_reg[i] <= du_dig_reg[i-1];
            end
        end
        if (em_load)
        begin
            em_dig_reg  <= du_dig_reg;
            em_last_reg <= du_last_reg;
        end
        else if (em_adv)
        begin
            for (int i = 0; i < NUM_DIGITS - 1; i++)
            begin
                em_dig_reg[i] <= em_dig_reg[i+1];
            end
            em_dig_reg[NUM_DIGITS-1] <= '0;
        end
        if (em_adv)
        begin
            symbol_reg     <= b85_symbol(em_dig_reg[0]);
            run_last_reg   <= em_final;
            stream_end_reg <= em_final && em_last_reg;
        end
    end

endmodule
